// ----- rtl/core/spring_force_acceleration_assert.svh -----
// ---------------------------------------------------------------------------
// Spring force acceleration assertion macros
// Shared forms for the concurrent checks of the spring force block.
// ---------------------------------------------------------------------------
`ifndef SPRING_FORCE_ACCELERATION_ASSERT_SVH
`define SPRING_FORCE_ACCELERATION_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SPFA_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
    else $error("spring_force_acceleration: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define SPFA_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
    else $error("spring_force_acceleration: next-cycle check failed");

`endif

// ----- rtl/core/spfa_pkg.sv -----
// ---------------------------------------------------------------------------
// Spring force acceleration package
// Widths, item types and register indexes shared by the spring force block.
// ---------------------------------------------------------------------------
`default_nettype none

package spfa_pkg;

  localparam int DW      = 32;
  localparam int MAG_W   = 33;
  localparam int SQ_W    = 66;
  localparam int SUM_W   = 66;
  localparam int ROOT_W  = 33;
  localparam int SQR_W   = 68;
  localparam int EXT_W   = 33;
  localparam int PROD_W  = 65;
  localparam int DEN_W   = 65;
  localparam int NUM_W   = 98;
  localparam int Q_W     = 32;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_STIFFNESS   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_REST_LENGTH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FREE_MASS   = 2'd2;

  localparam logic [DW-1:0] CFG_RESET_VALUE = 32'h0001_0000;

  typedef struct packed {
    logic signed [DW-1:0] anchor_x;
    logic signed [DW-1:0] anchor_y;
    logic signed [DW-1:0] anchor_z;
    logic signed [DW-1:0] body_x;
    logic signed [DW-1:0] body_y;
    logic signed [DW-1:0] body_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] accel_x;
    logic signed [DW-1:0] accel_y;
    logic signed [DW-1:0] accel_z;
    logic                 zero_length;
    logic                 saturated;
  } out_item_t;

  // Data that rides alongside the square root.
  typedef struct packed {
    logic                       zero;
    logic [2:0]                 neg;
    logic [2:0][MAG_W-1:0]      mag;
  } sqrt_side_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic       zero;
    logic [2:0] rneg;
  } div_side_t;

endpackage

`default_nettype wire

// ----- rtl/core/spfa_if.sv -----
// ---------------------------------------------------------------------------
// Spring force acceleration channels
// Input, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface spfa_in_if import spfa_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spfa_out_if import spfa_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spfa_cfg_if import spfa_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] reg_index;
  logic [DW-1:0]     wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/spring_force_acceleration.sv -----
// ---------------------------------------------------------------------------
// Spring force acceleration
// Hooke's-law acceleration change of a free mass tied to an anchored mass.
// ---------------------------------------------------------------------------
// The block takes one spring per item: the anchor and free-mass positions in
// signed Q16.16. It returns the acceleration change stiffness * (L - rest) *
// d / (L * mass), where d is the offset from the free mass to the anchor and
// L the floored Euclidean length, truncated toward zero and clipped to 32
// bits with the saturated flag set. Coincident endpoints give zero output and
// raise zero_length. One item enters every clock cycle unless the output stalls,
// and each item passes through these stages: three stages form the squared length, the
// square root takes one stage per root bit (33), four stages build the
// extension, products and divisor, the divider takes one stage per quotient
// bit plus an overflow stage (33), and the result register adds one. The
// whole pipeline holds still while a result waits at the output, so nothing
// is lost or repeated. Registers are written through the configuration
// channel, which is always ready; writes to an unused index are ignored and
// writes should only happen while no item is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

`include "spring_force_acceleration_assert.svh"

module spring_force_acceleration import spfa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spfa_in_if.sink    in_ch,
  spfa_out_if.source out_ch,
  spfa_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [DW-1:0] stiffness_r;
  logic [DW-1:0] rest_length_r;
  logic [DW-1:0] free_mass_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r   <= CFG_RESET_VALUE;
      rest_length_r <= CFG_RESET_VALUE;
      free_mass_r   <= CFG_RESET_VALUE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_STIFFNESS:   stiffness_r   <= cfg_ch.wdata;
        CFG_REST_LENGTH: rest_length_r <= cfg_ch.wdata;
        CFG_FREE_MASS:   free_mass_r   <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // The pipeline advances as one whenever the output register can move.
  logic out_valid_r;
  logic en;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: per-axis offset from the free mass toward the anchor.
  logic                   s1_v_r;
  logic [2:0][MAG_W-1:0]  s1_mag_r;
  logic [2:0]             s1_neg_r;
  logic [2:0][MAG_W-1:0]  s1_mag_nxt;
  logic [2:0]             s1_neg_nxt;
  logic [2:0][DW-1:0]     anc;
  logic [2:0][DW-1:0]     bod;

  assign anc = {in_ch.data.anchor_z, in_ch.data.anchor_y, in_ch.data.anchor_x};
  assign bod = {in_ch.data.body_z, in_ch.data.body_y, in_ch.data.body_x};

  always_comb begin
    logic [MAG_W-1:0] d;
    for (int i = 0; i < 3; i++) begin
      d             = {anc[i][DW-1], anc[i]} - {bod[i][DW-1], bod[i]};
      s1_neg_nxt[i] = d[MAG_W-1];
      s1_mag_nxt[i] = d[MAG_W-1] ? (MAG_W'(0) - d) : d;
    end
  end

  // Stage 2: squares of the offsets.
  logic                   s2_v_r;
  logic [2:0][SQ_W-1:0]   s2_sq_r;
  logic [2:0][MAG_W-1:0]  s2_mag_r;
  logic [2:0]             s2_neg_r;

  // Stage 3: squared length and the coincident-point test.
  logic                   s3_v_r;
  logic [SUM_W-1:0]       s3_sum_r;
  sqrt_side_t             s3_side_r;
  logic [SUM_W-1:0]       s3_sum_nxt;

  assign s3_sum_nxt = s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r <= s1_mag_nxt;
      s1_neg_r <= s1_neg_nxt;
      for (int i = 0; i < 3; i++) begin
        s2_sq_r[i] <= SQ_W'(s1_mag_r[i]) * SQ_W'(s1_mag_r[i]);
      end
      s2_mag_r       <= s1_mag_r;
      s2_neg_r       <= s1_neg_r;
      s3_sum_r       <= s3_sum_nxt;
      s3_side_r.zero <= (s3_sum_nxt == '0);
      s3_side_r.neg  <= s2_neg_r;
      s3_side_r.mag  <= s2_mag_r;
    end
  end

  // Floor square root of the squared length.
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  sqrt_side_t        sq_side;

  spfa_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_sum    (s3_sum_r),
    .in_side   (s3_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage 4: extension magnitude and sign, mass with zero taken as one.
  logic              s4_v_r;
  logic [EXT_W-1:0]  s4_ext_r;
  logic              s4_ext_neg_r;
  logic [ROOT_W-1:0] s4_root_r;
  logic [DW-1:0]     s4_mass_r;
  sqrt_side_t        s4_side_r;
  logic              s4_ext_neg_nxt;

  assign s4_ext_neg_nxt = sq_root < ROOT_W'(rest_length_r);

  // Stage 5: stiffness times extension, and length times mass as divisor.
  logic              s5_v_r;
  logic [PROD_W-1:0] s5_prod_r;
  logic [DEN_W-1:0]  s5_den_r;
  sqrt_side_t        s5_side_r;
  logic [2:0]        s5_rneg_r;

  // Stage 6: partial products of the numerator for each axis.
  logic                   s6_v_r;
  logic [2:0][SQ_W-1:0]   s6_lo_r;
  logic [2:0][PROD_W-1:0] s6_hi_r;
  logic [DEN_W-1:0]       s6_den_r;
  div_side_t              s6_side_r;

  // Stage 7: numerators assembled from the partial products.
  logic                   s7_v_r;
  logic [2:0][NUM_W-1:0]  s7_num_r;
  logic [DEN_W-1:0]       s7_den_r;
  div_side_t              s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= sq_v;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ext_neg_r <= s4_ext_neg_nxt;
      s4_ext_r     <= s4_ext_neg_nxt ? (EXT_W'(rest_length_r) - sq_root)
                                     : (sq_root - EXT_W'(rest_length_r));
      s4_root_r    <= sq_root;
      s4_mass_r    <= (free_mass_r == '0) ? DW'(1) : free_mass_r;
      s4_side_r    <= sq_side;

      s5_prod_r <= PROD_W'(stiffness_r) * PROD_W'(s4_ext_r);
      s5_den_r  <= DEN_W'(s4_root_r) * DEN_W'(s4_mass_r);
      s5_side_r <= s4_side_r;
      s5_rneg_r <= s4_side_r.neg ^ {3{s4_ext_neg_r}};

      for (int i = 0; i < 3; i++) begin
        s6_lo_r[i] <= SQ_W'(s5_prod_r[MAG_W-1:0]) * SQ_W'(s5_side_r.mag[i]);
        s6_hi_r[i] <= PROD_W'(s5_prod_r[PROD_W-1:MAG_W]) * PROD_W'(s5_side_r.mag[i]);
      end
      s6_den_r       <= s5_den_r;
      s6_side_r.zero <= s5_side_r.zero;
      s6_side_r.rneg <= s5_rneg_r;

      for (int i = 0; i < 3; i++) begin
        s7_num_r[i] <= NUM_W'(s6_lo_r[i]) + (NUM_W'(s6_hi_r[i]) << MAG_W);
      end
      s7_den_r  <= s6_den_r;
      s7_side_r <= s6_side_r;
    end
  end

  // Quotient of each numerator by length times mass.
  logic                 dv_v;
  logic [2:0][Q_W-1:0]  dv_quot;
  logic [2:0]           dv_ovf;
  div_side_t            dv_side;

  spfa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_num    (s7_num_r),
    .in_den    (s7_den_r),
    .in_side   (s7_side_r),
    .out_valid (dv_v),
    .out_quot  (dv_quot),
    .out_ovf   (dv_ovf),
    .out_side  (dv_side)
  );

  // Final stage: clip, apply the sign, and load the result register.
  out_item_t          out_r;
  out_item_t          out_nxt;
  logic [2:0][DW-1:0] acc;

  always_comb begin
    logic [Q_W-1:0] limit;
    logic [Q_W-1:0] m;
    logic           sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      limit = dv_side.rneg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      m     = dv_quot[i];
      if (dv_ovf[i] || (dv_quot[i] > limit)) begin
        m   = limit;
        sat = 1'b1;
      end
      acc[i] = dv_side.rneg[i] ? (DW'(0) - m) : m;
    end
    if (dv_side.zero) begin
      out_nxt = '0;
      out_nxt.zero_length = 1'b1;
    end else begin
      out_nxt.accel_x     = acc[0];
      out_nxt.accel_y     = acc[1];
      out_nxt.accel_z     = acc[2];
      out_nxt.zero_length = 1'b0;
      out_nxt.saturated   = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Summaries of the held result for the checks below.
  logic [2:0][DW-1:0] out_acc;
  logic               out_comp_zero;
  logic               out_at_limit;

  assign out_acc       = {out_r.accel_z, out_r.accel_y, out_r.accel_x};
  assign out_comp_zero = (out_acc == '0);

  always_comb begin
    out_at_limit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((out_acc[i] == 32'h7FFF_FFFF) || (out_acc[i] == 32'h8000_0000)) begin
        out_at_limit = 1'b1;
      end
    end
  end

  // A coincident result carries no clipping and zero components.
  `SPFA_ASSERT_IMP(a_zero_len_clean, clk, rst_n, out_valid_r && out_r.zero_length, !out_r.saturated && out_comp_zero)
  // A clipped result has at least one component at a limit.
  `SPFA_ASSERT_IMP(a_sat_at_limit, clk, rst_n, out_valid_r && out_r.saturated, out_at_limit)
  // A stalled pipeline keeps its valid bits in place.
  `SPFA_ASSERT_NXT(a_stall_holds, clk, rst_n, !en, $stable({s1_v_r, s4_v_r, s7_v_r}))

endmodule

`default_nettype wire

// ----- rtl/core/spfa_isqrt.sv -----
// ---------------------------------------------------------------------------
// Spring force pipelined square root
// Floor square root, one result bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module spfa_isqrt import spfa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SUM_W-1:0]  in_sum,
  input  wire sqrt_side_t        in_side,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output sqrt_side_t             out_side
);

  logic                    v_r    [ROOT_W];
  logic [SQR_W-1:0]        rem_r  [ROOT_W];
  logic [ROOT_W-1:0]       root_r [ROOT_W];
  sqrt_side_t              side_r [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int B = ROOT_W - 1 - g;
    logic              v_in;
    logic [SQR_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    sqrt_side_t        side_in;
    logic [SQR_W-1:0]  trial;
    logic [SQR_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = SQR_W'(in_sum);
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    assign trial = (SQR_W'(root_in) << (B + 1)) | (SQR_W'(1) << (2 * B));

    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/spfa_div.sv -----
// ---------------------------------------------------------------------------
// Spring force pipelined divider
// Three numerators over one divisor, 32 quotient bits, one bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module spfa_div import spfa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [2:0][NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]       in_den,
  input  wire div_side_t              in_side,
  output logic                        out_valid,
  output logic [2:0][Q_W-1:0]         out_quot,
  output logic [2:0]                  out_ovf,
  output div_side_t                   out_side
);

  localparam int NS = Q_W + 1;

  logic                   v_r    [NS];
  logic [2:0][NUM_W-1:0]  rem_r  [NS];
  logic [2:0][Q_W-1:0]    quot_r [NS];
  logic [2:0]             ovf_r  [NS];
  logic [DEN_W-1:0]       den_r  [NS];
  div_side_t              side_r [NS];

  // Stage 0: a quotient of 2^32 or more is flagged and not resolved further.
  logic [NUM_W-1:0] den_top;
  logic [2:0]       ovf_nxt;

  assign den_top = NUM_W'(in_den) << Q_W;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovf_nxt[i] = (in_num[i] >= den_top);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_num;
      quot_r[0] <= '0;
      ovf_r[0]  <= ovf_nxt;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 1; g < NS; g++) begin : g_stage
    localparam int K = Q_W - g;
    logic [NUM_W-1:0]      dsh;
    logic [2:0][NUM_W-1:0] rem_nxt;
    logic [2:0][Q_W-1:0]   quot_nxt;

    assign dsh = NUM_W'(den_r[g-1]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i]  = rem_r[g-1][i];
        quot_nxt[i] = quot_r[g-1][i];
        if (rem_r[g-1][i] >= dsh) begin
          rem_nxt[i]  = rem_r[g-1][i] - dsh;
          quot_nxt[i] = quot_r[g-1][i] | (Q_W'(1) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        quot_r[g] <= quot_nxt;
        ovf_r[g]  <= ovf_r[g-1];
        den_r[g]  <= den_r[g-1];
        side_r[g] <= side_r[g-1];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_quot  = quot_r[NS-1];
  assign out_ovf   = ovf_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

`default_nettype wire

// ----- verif/spfa_accel_checker.sv -----
// ---------------------------------------------------------------------------
// Spring force acceleration checker
// Watches the channels of the spring force block, works out the expected
// acceleration of every accepted item and compares each result with it.
// ---------------------------------------------------------------------------
`default_nettype none

module spfa_accel_checker import spfa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  spfa_in_if        in_ch,
  spfa_out_if       out_ch,
  spfa_cfg_if       cfg_ch,
  output int        fail_count,
  output int        accel_pending,
  output int        result_count,
  output int        zero_count,
  output int        clip_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DW-1:0] stiffness_q;
  logic [DW-1:0] rest_len_q;
  logic [DW-1:0] mass_q;
  out_item_t     accel_expected[$];

  // Exact Hooke's-law acceleration, truncated toward zero and clipped.
  function automatic out_item_t predict_accel(in_item_t it);
    longint             diff;
    bit [127:0]         mag[3];
    bit                 neg[3];
    bit [127:0]         sum, root, cand, ext, mass, num, quot, limit, clipped;
    bit                 ext_neg, rneg;
    logic signed [31:0] comp[3];
    out_item_t          res;
    logic signed [31:0] a[3];
    logic signed [31:0] b[3];
    a = '{it.anchor_x, it.anchor_y, it.anchor_z};
    b = '{it.body_x, it.body_y, it.body_z};
    sum = '0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      diff = longint'(a[i]) - longint'(b[i]);
      neg[i] = diff < 0;
      mag[i] = neg[i] ? 128'(-diff) : 128'(diff);
      sum += mag[i] * mag[i];
    end
    if (sum == 0) begin
      res.zero_length = 1'b1;
      return res;
    end
    root = '0;
    for (int k = 33; k >= 0; k--) begin
      cand = root | (128'd1 << k);
      if (cand * cand <= sum) root = cand;
    end
    ext_neg = root < 128'(rest_len_q);
    ext = ext_neg ? 128'(rest_len_q) - root : root - 128'(rest_len_q);
    mass = (mass_q == 0) ? 128'd1 : 128'(mass_q);
    for (int i = 0; i < 3; i++) begin
      num = 128'(stiffness_q) * ext * mag[i];
      quot = (num / root) / mass;
      rneg = ext_neg != neg[i];
      limit = rneg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (quot > limit) begin
        clipped = limit;
        res.saturated = 1'b1;
      end else begin
        clipped = quot;
      end
      comp[i] = rneg ? 32'(-clipped) : 32'(clipped);
    end
    res.accel_x = comp[0];
    res.accel_y = comp[1];
    res.accel_z = comp[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      stiffness_q <= CFG_RESET_VALUE;
      rest_len_q  <= CFG_RESET_VALUE;
      mass_q      <= CFG_RESET_VALUE;
      accel_expected.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_STIFFNESS:   stiffness_q <= cfg_ch.wdata;
          CFG_REST_LENGTH: rest_len_q  <= cfg_ch.wdata;
          CFG_FREE_MASS:   mass_q      <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) accel_expected.push_back(predict_accel(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        result_count++;
        if (got.zero_length) zero_count++;
        if (got.saturated) clip_count++;
        if (accel_expected.size() == 0) begin
          report_mismatch("unexpected result", got.accel_x, '0);
        end else begin
          want = accel_expected.pop_front();
          if (got.accel_x !== want.accel_x) report_mismatch("accel_x", got.accel_x, want.accel_x);
          if (got.accel_y !== want.accel_y) report_mismatch("accel_y", got.accel_y, want.accel_y);
          if (got.accel_z !== want.accel_z) report_mismatch("accel_z", got.accel_z, want.accel_z);
          if (got.zero_length !== want.zero_length)
            report_mismatch("zero_length", 32'(got.zero_length), 32'(want.zero_length));
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        end
      end
    end
    accel_pending = accel_expected.size();
  end

endmodule

`default_nettype wire

// ----- verif/tb_spring_force_acceleration.sv -----
// ---------------------------------------------------------------------------
// Spring force acceleration testbench
// Drives springs and register settings into the block, with bursty input and
// a stalling receiver, and leaves all checking to the checker beside it.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_spring_force_acceleration;
  import spfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The index width leaves one unused register slot; writes to it are dropped.
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
  // Extra wait after the last result, so the whole pipeline drains out.
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1150;

  logic clk;
  logic rst_n;
  int   fail_count, accel_pending, result_count, zero_count, clip_count;
  int   burst_left;
  int   cycle_count;

  spfa_in_if  in_ch();
  spfa_out_if out_ch();
  spfa_cfg_if cfg_ch();

  spring_force_acceleration dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  spfa_accel_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .accel_pending (accel_pending),
    .result_count  (result_count),
    .zero_count    (zero_count),
    .clip_count    (clip_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input is known from time zero, so nothing the block samples is X.
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = CFG_STIFFNESS;
    cfg_ch.wdata = '0;
  end

  // The receiver alternates between stretches of constant readiness and
  // stretches of random stalls, so back-pressure lands on every pipeline phase.
  initial begin
    int stretch;
    int stall_odds;
    forever begin
      stretch = $urandom_range(10, 120);
      stall_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 70);
      repeat (stretch) begin
        @(negedge clk);
        out_ch.ready = ($urandom_range(0, 99) >= stall_odds);
      end
    end
  end

  // The run is cut short when the cycle counter reaches CYCLE_LIMIT.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Offers one spring to the block. The sender works in bursts: when a burst
  // is used up, valid drops for a random gap, which may be empty, before the next burst begins.
  task automatic send_spring(in_item_t it);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Waits until every result is home, then lets the pipeline drain fully.
  task automatic drain_pipeline();
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (accel_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [DW-1:0] value);
    cfg_ch.valid     = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.wdata     = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_spring(logic [DW-1:0] k, logic [DW-1:0] rest, logic [DW-1:0] m);
    drain_pipeline();
    write_reg(CFG_STIFFNESS, k);
    write_reg(CFG_REST_LENGTH, rest);
    write_reg(CFG_FREE_MASS, m);
  endtask

  function automatic in_item_t make_spring(int ax, int ay, int az, int bx, int by, int bz);
    in_item_t it;
    it.anchor_x = ax; it.anchor_y = ay; it.anchor_z = az;
    it.body_x = bx;   it.body_y = by;   it.body_z = bz;
    return it;
  endfunction

  // Random springs: mostly physically sensible ones with the free mass a few
  // units from the anchor, plus full-range noise, coincident endpoints and endpoints one step apart.
  function automatic in_item_t random_spring();
    in_item_t it;
    int       kind;
    kind = $urandom_range(0, 19);
    it.anchor_x = $urandom; it.anchor_y = $urandom; it.anchor_z = $urandom;
    if (kind < 12) begin
      it.body_x = it.anchor_x + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.body_y = it.anchor_y + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.body_z = it.anchor_z + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    end else if (kind < 13) begin
      it.body_x = it.anchor_x; it.body_y = it.anchor_y; it.body_z = it.anchor_z;
    end else if (kind < 14) begin
      it.body_x = it.anchor_x + $signed($urandom_range(0, 2)) - 1;
      it.body_y = it.anchor_y;
      it.body_z = it.anchor_z + $signed($urandom_range(0, 2)) - 1;
    end else begin
      it.body_x = $urandom; it.body_y = $urandom; it.body_z = $urandom;
    end
    return it;
  endfunction

  initial begin
    int sent;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed springs under the reset setting: coincident endpoints, the
    // widest offsets in both directions, each axis alone, an extension of
    // exactly zero and a spring shorter than its rest length.
    send_spring(make_spring(0, 0, 0, 0, 0, 0));
    send_spring(make_spring(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_spring(make_spring(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_spring(make_spring(32'sh0003_0000, 0, 0, 0, 0, 0));
    send_spring(make_spring(0, -32'sh0003_0000, 0, 0, 0, 0));
    send_spring(make_spring(0, 0, 32'sh0005_8000, 0, 0, 0));
    send_spring(make_spring(32'sh0001_0000, 0, 0, 0, 0, 0));
    send_spring(make_spring(32'sh0000_4000, 32'sh0000_4000, 0, 0, 0, 0));
    send_spring(make_spring(1, 0, 0, 0, 0, 0));
    send_spring(make_spring(-7, 5, 32'sh8000_0000, 3, -2, 32'sh8000_0000));

    // Heaviest spring and lightest mass: almost everything clips. Mass zero
    // stands for the smallest mass.
    set_spring(32'hffff_ffff, 32'h0000_0000, 32'h0000_0001);
    send_spring(make_spring(32'sh7fff_ffff, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7fff_ffff));
    send_spring(make_spring(32'sh0000_0010, 0, 0, 0, 0, 0));
    send_spring(make_spring(0, 0, 0, 0, 0, 0));
    set_spring(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
    send_spring(make_spring(32'sh0002_0000, -32'sh0001_0000, 0, 0, 0, 0));
    send_spring(make_spring(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    // A write to the unused index must leave the setting alone.
    set_spring(32'h0000_0000, 32'h0001_0000, 32'hffff_ffff);
    write_reg(CFG_UNUSED, 32'h1234_5678);
    send_spring(make_spring(32'sh0004_0000, 0, 0, 0, 0, 0));
    set_spring(32'h0002_0000, 32'h0001_8000, 32'hffff_ffff);
    send_spring(make_spring(32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0));

    // Random phases, each under a setting of its own. Halfway through a phase
    // the sender holds off until every outstanding result has come back.
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_spring(CFG_RESET_VALUE, CFG_RESET_VALUE, CFG_RESET_VALUE);
        1: set_spring(32'hffff_ffff, 32'h0000_0000, 32'h0000_0001);
        2: set_spring(32'h0000_0000, $urandom, $urandom);
        3: set_spring($urandom_range(1, 32'h0010_0000), $urandom_range(0, 32'h0004_0000),
                      $urandom_range(32'h0000_4000, 32'h0004_0000));
        4: set_spring($urandom, $urandom, 32'h0000_0000);
        5: set_spring($urandom, 32'hffff_ffff, 32'hffff_ffff);
        default: set_spring($urandom, $urandom_range(0, 32'h0008_0000), $urandom);
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
        if (n == RANDOM_ITEMS / 16) drain_pipeline();
        send_spring(random_spring());
        sent++;
      end
    end

    drain_pipeline();
    $display("run covered %0d random springs over 8 settings plus directed cases", sent);
    $display("%0d results checked: %0d coincident, %0d clipped", result_count, zero_count,
             clip_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/spfa_pkg.sv
rtl/core/spfa_if.sv
rtl/core/spfa_isqrt.sv
rtl/core/spfa_div.sv
rtl/core/spring_force_acceleration.sv
verif/spfa_accel_checker.sv
verif/tb_spring_force_acceleration.sv
